@@ rtl/act_pkg.sv @@
// Shared types and codes for the ALOHA collision tracker.
package act_pkg;

   // Item kinds on the request channel
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_END   = 1'b1;

   // Result status codes
   typedef enum logic [2:0] {
      ST_ACCEPTED  = 3'd0,
      ST_DELIVERED = 3'd1,
      ST_LOST      = 3'd2,
      ST_FULL      = 3'd3,
      ST_UNKNOWN   = 3'd4
   } status_type;

   // Time arithmetic
   localparam int TIME_W = 48;
   localparam int DUR_W  = 32;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   // Command from the datapath to the packet table
   typedef struct packed {
      logic       update;
      logic       is_start;
      logic       window_open;
      logic [7:0] src;
      logic [7:0] tag;
      logic [7:0] dest;
   } tbl_cmd_type;

   // Lookup results from the packet table
   typedef struct packed {
      logic       full;
      logic       hit;
      logic       hit_collided;
      logic [7:0] hit_dest;
      logic       empty_after;
   } tbl_rsp_type;

endpackage

@@ rtl/act_channels.sv @@
// Request and response channel interfaces for the ALOHA collision tracker.
interface act_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [47:0] now_time;
   logic [31:0] duration;
   logic [7:0]  source_id;
   logic [7:0]  packet_tag;
   logic [7:0]  dest_id;

   modport source (output valid, kind, now_time, duration, source_id, packet_tag, dest_id,
                   input ready);
   modport sink   (input valid, kind, now_time, duration, source_id, packet_tag, dest_id,
                   output ready);
endinterface

interface act_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] tag_out;
   logic [7:0] dest_out;

   modport source (output valid, status, tag_out, dest_out, input ready);
   modport sink   (input valid, status, tag_out, dest_out, output ready);
endinterface

@@ rtl/act_table.sv @@
// Associative table of packets in flight: tag search, free slot search, collision marks.
module act_table #(
   parameter int IN_FLIGHT   = 16,
   parameter int SOURCE_BITS = 8,
   parameter int TAG_BITS    = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  act_pkg::tbl_cmd_type cmd,
   output act_pkg::tbl_rsp_type rsp
);
   import act_pkg::*;

   localparam int IDX_W = $clog2(IN_FLIGHT);
   localparam int SRC_W = (SOURCE_BITS < 8) ? SOURCE_BITS : 8;
   localparam int TAG_W = (TAG_BITS < 8) ? TAG_BITS : 8;

   logic [IN_FLIGHT-1:0] valid_ff, valid_in;
   logic [IN_FLIGHT-1:0] collided_ff, collided_in;
   logic [SRC_W-1:0]     source_ff [IN_FLIGHT];
   logic [TAG_W-1:0]     tag_ff    [IN_FLIGHT];
   logic [7:0]           dest_ff   [IN_FLIGHT];

   logic [IN_FLIGHT-1:0] src_diff;
   logic [IN_FLIGHT-1:0] hit_sel;
   logic                 free_found, hit_found;
   logic [IDX_W-1:0]     free_idx, hit_idx;
   logic                 clash;
   logic                 add_entry, drop_entry;

   // Parallel compares and lowest-index priority picks
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      hit_found  = 1'b0;
      hit_idx    = '0;
      hit_sel    = '0;
      src_diff   = '0;
      for (int i = 0; i < IN_FLIGHT; i++) begin
         src_diff[i] = valid_ff[i] && (source_ff[i] != cmd.src[SRC_W-1:0]);
         if (!valid_ff[i] && !free_found) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
         if (valid_ff[i] && (tag_ff[i] == cmd.tag[TAG_W-1:0]) && !hit_found) begin
            hit_found  = 1'b1;
            hit_idx    = IDX_W'(i);
            hit_sel[i] = 1'b1;
         end
      end
   end

   assign clash      = cmd.window_open && (|src_diff);
   assign add_entry  = cmd.update && cmd.is_start && free_found;
   assign drop_entry = cmd.update && !cmd.is_start && hit_found;

   always_comb begin
      rsp.full         = !free_found;
      rsp.hit          = hit_found;
      rsp.hit_collided = collided_ff[hit_idx];
      rsp.hit_dest     = dest_ff[hit_idx];
      rsp.empty_after  = ((valid_ff & ~hit_sel) == '0);
   end

   // Next valid bits and collision marks
   always_comb begin
      valid_in    = valid_ff;
      collided_in = collided_ff;
      if (add_entry) begin
         if (clash) begin
            collided_in = collided_ff | valid_ff;
         end
         valid_in[free_idx]    = 1'b1;
         collided_in[free_idx] = clash;
      end else if (drop_entry) begin
         valid_in = valid_ff & ~hit_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Entry payload, no reset: read only behind a valid bit
   always_ff @(posedge clock) begin
      collided_ff <= collided_in;
      if (add_entry) begin
         source_ff[free_idx] <= cmd.src[SRC_W-1:0];
         tag_ff[free_idx]    <= cmd.tag[TAG_W-1:0];
         dest_ff[free_idx]   <= cmd.dest;
      end
   end

`ifndef NO_ASSERTIONS
   a_add_one: assert property (@(posedge clock) disable iff (reset)
      add_entry |=> $countones(valid_ff) == $past($countones(valid_ff)) + 1)
      else $error("table start did not open exactly one entry");
   a_drop_one: assert property (@(posedge clock) disable iff (reset)
      drop_entry |=> $countones(valid_ff) == $past($countones(valid_ff)) - 1)
      else $error("table end did not free exactly one entry");
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      !free_found |-> $countones(valid_ff) == IN_FLIGHT)
      else $error("table reports full with free entries");
`endif

endmodule

@@ rtl/act_window.sv @@
// Busy window bounds: saturating end time, widening and closing.
module act_window (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       is_start,
   input  logic [act_pkg::TIME_W-1:0] now_time,
   input  logic [act_pkg::DUR_W-1:0]  duration,
   input  act_pkg::tbl_rsp_type       tbl_rsp,
   output logic                       window_open
);
   import act_pkg::*;

   logic [TIME_W-1:0] start_ff, start_in;
   logic [TIME_W-1:0] end_ff, end_in;
   logic [TIME_W:0]   sum;
   logic [TIME_W-1:0] fin;

   assign window_open = (start_ff != end_ff);

   // Saturating end of this packet's airtime
   assign sum = {1'b0, now_time} + {{(TIME_W+1-DUR_W){1'b0}}, duration};
   assign fin = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

   // Window update
   always_comb begin
      start_in = start_ff;
      end_in   = end_ff;
      if (advance) begin
         if (is_start) begin
            if (!tbl_rsp.full) begin
               start_in = now_time;
               if (!window_open || (end_ff < fin)) begin
                  end_in = fin;
               end
            end
         end else if (tbl_rsp.hit && tbl_rsp.empty_after && (now_time == end_ff)) begin
            start_in = '0;
            end_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         end_ff   <= '0;
      end else begin
         start_ff <= start_in;
         end_ff   <= end_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_open_grows: assert property (@(posedge clock) disable iff (reset)
      (advance && is_start && !tbl_rsp.full && window_open) |=> end_ff >= $past(end_ff))
      else $error("open window end moved backwards");
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (advance && is_start && tbl_rsp.full) |=> $stable(start_ff) && $stable(end_ff))
      else $error("window changed on a full table");
`endif

endmodule

@@ rtl/aloha_collision_tracker_unit.sv @@
// Top level of the ALOHA collision tracker: input register, table pass, result register.
// A request word is held in the input register, then in the result register, from which its response is offered.
// Throughput: one word per cycle while the response is not stalled; the single table search and update pass sits
// between the input register and the result register.
// A stalled response holds the result register; one more request waits in the input register.
// Reset (synchronous) clears all entry valid bits and both window bounds; no clearing pass.
module aloha_collision_tracker_unit #(
   parameter int IN_FLIGHT   = 16,
   parameter int SOURCE_BITS = 8,
   parameter int TAG_BITS    = 8
) (
   input  logic      clock,
   input  logic      reset,
   act_req_if.sink   req_chan,
   act_rsp_if.source rsp_chan
);
   import act_pkg::*;

   localparam int SRC_W = (SOURCE_BITS < 8) ? SOURCE_BITS : 8;
   localparam int TAG_W = (TAG_BITS < 8) ? TAG_BITS : 8;
   localparam logic [7:0] SRC_MASK = 8'((1 << SRC_W) - 1);
   localparam logic [7:0] TAG_MASK = 8'((1 << TAG_W) - 1);

   // Input register
   logic              s1_valid_ff, s1_valid_in;
   logic              kind_ff;
   logic [TIME_W-1:0] now_ff;
   logic [DUR_W-1:0]  dur_ff;
   logic [7:0]        src_ff, tag_ff, dest_ff;

   // Result register
   logic       out_valid_ff, out_valid_in;
   status_type status_ff, status_in;
   logic [7:0] tag_out_ff;
   logic [7:0] dest_out_ff, dest_out_in;

   logic        advance, req_take, is_start, window_open;
   tbl_cmd_type tbl_cmd;
   tbl_rsp_type tbl_rsp;

   // Handshake and flow
   assign advance        = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign is_start       = (kind_ff == KIND_START);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Request word capture
   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff <= req_chan.kind;
         now_ff  <= req_chan.now_time;
         dur_ff  <= req_chan.duration;
         src_ff  <= req_chan.source_id & SRC_MASK;
         tag_ff  <= req_chan.packet_tag & TAG_MASK;
         dest_ff <= req_chan.dest_id;
      end
   end

   // Table and window
   always_comb begin
      tbl_cmd.update      = advance;
      tbl_cmd.is_start    = is_start;
      tbl_cmd.window_open = window_open;
      tbl_cmd.src         = src_ff;
      tbl_cmd.tag         = tag_ff;
      tbl_cmd.dest        = dest_ff;
   end

   act_table #(
      .IN_FLIGHT   (IN_FLIGHT),
      .SOURCE_BITS (SOURCE_BITS),
      .TAG_BITS    (TAG_BITS)
   ) u_table (
      .clock (clock),
      .reset (reset),
      .cmd   (tbl_cmd),
      .rsp   (tbl_rsp)
   );

   act_window u_window (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .is_start    (is_start),
      .now_time    (now_ff),
      .duration    (dur_ff),
      .tbl_rsp     (tbl_rsp),
      .window_open (window_open)
   );

   // Result word
   always_comb begin
      dest_out_in = 8'd0;
      if (is_start) begin
         status_in = tbl_rsp.full ? ST_FULL : ST_ACCEPTED;
      end else if (!tbl_rsp.hit) begin
         status_in = ST_UNKNOWN;
      end else if (tbl_rsp.hit_collided) begin
         status_in = ST_LOST;
      end else begin
         status_in   = ST_DELIVERED;
         dest_out_in = tbl_rsp.hit_dest;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         status_ff   <= status_in;
         tag_out_ff  <= tag_ff;
         dest_out_ff <= dest_out_in;
      end
   end

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.status   = status_ff;
   assign rsp_chan.tag_out  = tag_out_ff;
   assign rsp_chan.dest_out = dest_out_ff;

`ifndef NO_ASSERTIONS
   a_rsp_from_pass: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(advance))
      else $error("response word appeared without a table pass");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> s1_valid_ff)
      else $error("stalled request word was dropped");
   a_not_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (s1_valid_ff && out_valid_ff))
      else $error("request refused with room in the pipeline");
`endif

endmodule
